// File: hdl/sdrt_pkg.sv
// sdrt_pkg: shared types, sizes and codes for the sorted distinct rank table
// used by the cell, the reduce tree and the top level
// no dependencies
package sdrt_pkg;

  // store size and derived widths
  localparam int CAPACITY  = 1024;
  localparam int CNT_W     = $clog2(CAPACITY + 1);
  localparam int FIELD_W   = 11;
  localparam int CMP_W     = (CNT_W > FIELD_W) ? CNT_W : FIELD_W;
  localparam int VAL_W     = 32;

  // reduce tree shape: about sqrt(CAPACITY) per group
  localparam int LG_CAP    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int GRP_LG    = (LG_CAP + 1) / 2;
  localparam int GROUP     = 1 << GRP_LG;
  localparam int NGROUPS   = (CAPACITY + GROUP - 1) / GROUP;

  // mode codes
  localparam logic [1:0] MODE_ADD    = 2'd0;
  localparam logic [1:0] MODE_RANK   = 2'd1;
  localparam logic [1:0] MODE_LOOKUP = 2'd2;

  // status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_RANGE = 2'd2;

  typedef struct packed {
    logic [1:0]               mode;
    logic signed [VAL_W-1:0]  item_value;
    logic [FIELD_W-1:0]       rank_in;
  } in_t;

  typedef struct packed {
    logic [FIELD_W-1:0]       rank_out;
    logic signed [VAL_W-1:0]  value_out;
    logic [FIELD_W-1:0]       distinct_count;
    logic [1:0]               status;
  } out_t;

  // what each cell offers to the reduce tree; at most one cell drives each field
  typedef struct packed {
    logic [VAL_W-1:0] val;
    logic [CNT_W-1:0] rank;
    logic             dup;
  } contrib_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CMP,
    S_RED1,
    S_RED2,
    S_DONE
  } state_t;

endpackage

// File: hdl/sdrt_cell.sv
// sdrt_cell: one slot of the sorted chain, holds a value and its valid bit
// depends on sdrt_pkg
module sdrt_cell
  import sdrt_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst,
  input  logic [CNT_W-1:0]        pos,
  input  logic signed [VAL_W-1:0] query,
  input  logic [CNT_W-1:0]        rank_sel,
  input  logic                    cmp_en,
  input  logic                    ins_en,
  input  logic signed [VAL_W-1:0] prev_val,
  input  logic                    prev_valid,
  input  logic                    prev_le,
  input  logic                    next_le,
  output logic signed [VAL_W-1:0] val,
  output logic                    valid,
  output logic                    le,
  output contrib_t                contrib
);

  logic eq;

  // compare against the query, held until the next compare
  always_ff @(posedge clk) begin
    if (rst) begin
      le <= 1'b0;
      eq <= 1'b0;
    end else if (cmp_en) begin
      le <= valid && (val <= query);
      eq <= valid && (val == query);
    end
  end

  // insertion: the insert cell takes the query, cells above it the left neighbor's value
  always_ff @(posedge clk) begin
    if (ins_en && !le) begin
      val <= prev_le ? query : prev_val;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (ins_en) begin
      valid <= valid | prev_valid;
    end
  end

  // offer: own value when selected by rank, own position at the le boundary, own equal flag
  always_comb begin
    contrib.val  = (valid && (pos == rank_sel)) ? val : '0;
    contrib.rank = (le && !next_le) ? pos : '0;
    contrib.dup  = eq;
  end

endmodule

// File: hdl/sdrt_reduce.sv
// sdrt_reduce: two-level registered or-tree over the cell offers
// depends on sdrt_pkg
module sdrt_reduce
  import sdrt_pkg::*;
(
  input  logic     clk,
  input  contrib_t leaf [CAPACITY],
  output contrib_t root
);

  contrib_t grp [NGROUPS];
  contrib_t grp_or [NGROUPS];
  contrib_t root_or;

  // first level: or within each group
  always_comb begin
    for (int g = 0; g < NGROUPS; g++) begin
      grp_or[g] = '0;
      for (int k = 0; k < GROUP; k++) begin
        if (g * GROUP + k < CAPACITY) begin
          grp_or[g] = grp_or[g] | leaf[g * GROUP + k];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    grp <= grp_or;
  end

  // second level: or across groups
  always_comb begin
    root_or = '0;
    for (int g = 0; g < NGROUPS; g++) begin
      root_or = root_or | grp[g];
    end
  end

  always_ff @(posedge clk) begin
    root <= root_or;
  end

endmodule

// File: hdl/sorted_distinct_rank_table.sv
// sorted_distinct_rank_table: a chain of CAPACITY cells keeps distinct signed
// values in ascending order. After the accepting edge busy stays high and done
// rises when busy falls, staying high for one cycle. In order, every cell
// compares against the query and registers the result, the two registered levels
// of the or-tree gather the rank, duplicate flag and looked-up value, and the final
// step forms the result and shifts the upper cells on an insert. The result cannot
// be held off; no new request is taken while busy, and a new transaction may be
// started in the same cycle that done is shown.
// depends on sdrt_pkg, sdrt_cell, sdrt_reduce
module sorted_distinct_rank_table
  import sdrt_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic start,
  output logic busy,
  input  in_t  req,
  output logic done,
  output out_t res
);

  state_t state, state_next;
  in_t    req_q;
  logic [CNT_W-1:0] count, count_next;
  logic   cmp_en, ins_en;
  out_t   res_next;
  logic   done_next;

  logic signed [VAL_W-1:0] cell_val   [CAPACITY];
  logic                    cell_valid [CAPACITY];
  logic                    cell_le    [CAPACITY];
  contrib_t                offer      [CAPACITY];
  contrib_t                red;

  assign busy = (state != S_IDLE);

  // capture the request
  always_ff @(posedge clk) begin
    if (start && !busy) begin
      req_q <= req;
    end
  end

  // cell chain
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    sdrt_cell u_cell (
      .clk        (clk),
      .rst        (rst),
      .pos        (CNT_W'(i + 1)),
      .query      (req_q.item_value),
      .rank_sel   (CNT_W'(req_q.rank_in)),
      .cmp_en     (cmp_en),
      .ins_en     (ins_en),
      .prev_val   ((i == 0) ? '0 : cell_val[(i == 0) ? 0 : i - 1]),
      .prev_valid ((i == 0) ? 1'b1 : cell_valid[(i == 0) ? 0 : i - 1]),
      .prev_le    ((i == 0) ? 1'b1 : cell_le[(i == 0) ? 0 : i - 1]),
      .next_le    ((i == CAPACITY - 1) ? 1'b0
                   : cell_le[(i == CAPACITY - 1) ? i : i + 1]),
      .val        (cell_val[i]),
      .valid      (cell_valid[i]),
      .le         (cell_le[i]),
      .contrib    (offer[i])
    );
  end

  sdrt_reduce u_reduce (
    .clk  (clk),
    .leaf (offer),
    .root (red)
  );

  // state and result registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      done  <= done_next;
    end
  end

  always_ff @(posedge clk) begin
    if (done_next) begin
      res <= res_next;
    end
  end

  // sequencer and result forming
  always_comb begin
    state_next = state;
    count_next = count;
    cmp_en     = 1'b0;
    ins_en     = 1'b0;
    done_next  = 1'b0;
    res_next   = '0;
    case (state)
      S_IDLE: begin
        if (start) begin
          state_next = S_CMP;
        end
      end
      S_CMP: begin
        cmp_en     = 1'b1;
        state_next = S_RED1;
      end
      S_RED1: begin
        state_next = S_RED2;
      end
      S_RED2: begin
        state_next = S_DONE;
      end
      S_DONE: begin
        done_next  = 1'b1;
        state_next = S_IDLE;
        case (req_q.mode)
          MODE_ADD: begin
            if (!red.dup) begin
              if (count == CNT_W'(CAPACITY)) begin
                res_next.status = ST_FULL;
              end else begin
                ins_en = 1'b1;
              end
            end
          end
          MODE_RANK: begin
            res_next.rank_out = FIELD_W'(red.rank);
          end
          MODE_LOOKUP: begin
            if (req_q.rank_in == '0 || CMP_W'(req_q.rank_in) > CMP_W'(count)) begin
              res_next.status = ST_RANGE;
            end else begin
              res_next.value_out = red.val;
            end
          end
          default: begin
          end
        endcase
        count_next              = count + CNT_W'(ins_en);
        res_next.distinct_count = FIELD_W'(count_next);
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

`ifndef SYNTH
  // a result only follows the final sequencer step
  a_done_after_final: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(state == S_DONE))
    else $error("result strobe without final step");

  // the distinct count never passes the store size
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    CMP_W'(count) <= CMP_W'(CAPACITY))
    else $error("distinct count above capacity");

  // the count only grows, by one, at the final step of a transaction
  a_count_step: assert property (@(posedge clk) disable iff (rst)
    (count != $past(count)) |-> (done && count == $past(count) + CNT_W'(1)))
    else $error("distinct count changed unexpectedly");

  // a dropped value is reported only with the store full
  a_full_status: assert property (@(posedge clk) disable iff (rst)
    (done && res.status == ST_FULL) |-> (count == CNT_W'(CAPACITY)))
    else $error("full status with room left");
`endif

endmodule

// File: sim/tb_sorted_distinct_rank_table.sv
// tb_sorted_distinct_rank_table: self-checking bench for the sorted distinct rank table,
// with its own shadow of the ordered store, a request driver and a result monitor
// depends on sdrt_pkg and sorted_distinct_rank_table
module tb_sorted_distinct_rank_table;
  import sdrt_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] MODE_UNUSED = 2'd3;
  localparam logic signed [VAL_W-1:0] VAL_MIN = 32'sh8000_0000;
  localparam logic signed [VAL_W-1:0] VAL_MAX = 32'sh7fff_ffff;
  localparam int IDLE_PCT = 29;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  in_t  req = '0;
  logic busy;
  logic done;
  out_t res;

  // requests waiting to be driven, results waiting to be seen
  in_t  queued_requests[$];
  out_t pending_table_results[$];
  int   requests_taken = 0;
  bit   mismatch_seen = 1'b0;

  // shadow of the ordered store
  logic signed [VAL_W-1:0] shadow_vals[CAPACITY];
  int shadow_size = 0;

  // values the stimulus has stored so far, for duplicates and hits
  logic signed [VAL_W-1:0] stored_list[$];
  bit stored_set[int];

  sorted_distinct_rank_table dut (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .req   (req),
    .done  (done),
    .res   (res)
  );

  // clock
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // number of held values not greater than v
  function automatic int count_not_above(logic signed [VAL_W-1:0] v);
    int lo;
    int hi;
    int mid;
    lo = 0;
    hi = shadow_size;
    while (lo < hi) begin
      mid = lo + (hi - lo) / 2;
      if (shadow_vals[mid] <= v) lo = mid + 1;
      else hi = mid;
    end
    return lo;
  endfunction

  // apply one transaction to the shadow store and form its result
  function automatic out_t next_table_result(in_t item);
    out_t r;
    int pos;
    bit dup;
    r = '0;
    case (item.mode)
      MODE_ADD: begin
        pos = count_not_above(item.item_value);
        dup = (pos > 0) && (shadow_vals[pos-1] == item.item_value);
        if (!dup) begin
          if (shadow_size >= CAPACITY) begin
            r.status = ST_FULL;
          end else begin
            for (int i = shadow_size; i > pos; i--) shadow_vals[i] = shadow_vals[i-1];
            shadow_vals[pos] = item.item_value;
            shadow_size++;
          end
        end
      end
      MODE_RANK: begin
        r.rank_out = FIELD_W'(count_not_above(item.item_value));
      end
      MODE_LOOKUP: begin
        if (item.rank_in == 0 || item.rank_in > shadow_size) r.status = ST_RANGE;
        else r.value_out = shadow_vals[item.rank_in - 1];
      end
      default: ;
    endcase
    r.distinct_count = shadow_size[FIELD_W-1:0];
    return r;
  endfunction

  // stimulus side: queue a request and track what it stores
  task automatic queue_item(logic [1:0] m, logic signed [VAL_W-1:0] v, logic [FIELD_W-1:0] r);
    in_t it;
    it.mode = m;
    it.item_value = v;
    it.rank_in = r;
    queued_requests.insert(queued_requests.size(), it);
    if (m == MODE_ADD && !stored_set.exists(v) && stored_set.num() < CAPACITY) begin
      stored_set[v] = 1'b1;
      stored_list.insert(stored_list.size(), v);
    end
  endtask

  // fresh values, stored ones or their neighbors, sometimes extremes or small values
  function automatic logic signed [VAL_W-1:0] pick_value();
    int sel;
    int idx;
    sel = $urandom_range(0, 99);
    if (stored_list.size() == 0 || sel < 40) return $urandom;
    idx = $urandom_range(0, stored_list.size() - 1);
    if (sel < 70) return stored_list[idx];
    if (sel < 85) return stored_list[idx] + ($urandom_range(0, 1) ? 1 : -1);
    case ($urandom_range(0, 4))
      0: return VAL_MIN;
      1: return VAL_MAX;
      2: return 0;
      3: return -1;
      default: return $signed($urandom_range(0, 15)) - 8;
    endcase
  endfunction

  // mostly valid ranks, some out of range or zero
  function automatic logic [FIELD_W-1:0] pick_rank();
    int held;
    held = stored_set.num();
    if ($urandom_range(0, 99) < 15 || held == 0) return FIELD_W'($urandom_range(0, 2047));
    return FIELD_W'($urandom_range(1, held + 1));
  endfunction

  task automatic queue_random(int add_pct);
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 3) queue_item(MODE_UNUSED, $urandom, FIELD_W'($urandom_range(0, 2047)));
    else if (sel < 3 + add_pct)
      queue_item(MODE_ADD, pick_value(), FIELD_W'($urandom_range(0, 2047)));
    else if (sel % 2) queue_item(MODE_RANK, pick_value(), FIELD_W'($urandom_range(0, 2047)));
    else queue_item(MODE_LOOKUP, $urandom, pick_rank());
  endtask

  // random hold-off, none over a stretch in the middle of the run
  function automatic bit hold_off();
    if (requests_taken >= 300 && requests_taken < 450) return 1'b0;
    return $urandom_range(0, 99) < IDLE_PCT;
  endfunction

  // driver: record accepted transactions, present the next one
  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
      req <= '0;
    end else begin
      if (start && !busy) begin
        pending_table_results.insert(pending_table_results.size(), next_table_result(req));
        requests_taken++;
      end
      if (!start || !busy) begin
        if (queued_requests.size() > 0 && !hold_off()) begin
          req <= queued_requests.pop_front();
          start <= 1'b1;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  task automatic check_field(string fname, logic [VAL_W-1:0] want_v, logic [VAL_W-1:0] got_v);
    if (want_v !== got_v) begin
      $display("%0t ns: %s mismatch, expected %0h, got %0h", $time, fname, want_v, got_v);
      mismatch_seen = 1'b1;
    end
  endtask

  // monitor: compare each strobed result with the oldest expectation
  always @(posedge clk) begin : result_check
    out_t want;
    if (!rst && done) begin
      if (pending_table_results.size() == 0) begin
        $display("%0t ns: result with none expected, expected nothing, got %p", $time, res);
        mismatch_seen = 1'b1;
      end else begin
        want = pending_table_results.pop_front();
        check_field("rank_out", VAL_W'(want.rank_out), VAL_W'(res.rank_out));
        check_field("value_out", want.value_out, res.value_out);
        check_field("distinct_count", VAL_W'(want.distinct_count),
                    VAL_W'(res.distinct_count));
        check_field("status", VAL_W'(want.status), VAL_W'(res.status));
      end
    end
  end

  // stimulus and end of run
  initial begin
    // empty store, then extremes, duplicates and edge ranks
    queue_item(MODE_LOOKUP, 0, 1);
    queue_item(MODE_RANK, VAL_MIN, 0);
    queue_item(MODE_ADD, VAL_MIN, 0);
    queue_item(MODE_ADD, VAL_MAX, 0);
    queue_item(MODE_ADD, 0, 0);
    queue_item(MODE_ADD, -1, 0);
    queue_item(MODE_ADD, 0, 0);
    queue_item(MODE_ADD, VAL_MIN, 0);
    queue_item(MODE_RANK, VAL_MIN, 0);
    queue_item(MODE_RANK, VAL_MAX, 0);
    queue_item(MODE_RANK, -2, 0);
    queue_item(MODE_RANK, 1, 0);
    queue_item(MODE_RANK, -1, 0);
    queue_item(MODE_LOOKUP, 0, 0);
    queue_item(MODE_LOOKUP, 0, 1);
    queue_item(MODE_LOOKUP, 0, 4);
    queue_item(MODE_LOOKUP, 0, 5);
    queue_item(MODE_LOOKUP, -1, 11'h7ff);
    queue_item(MODE_UNUSED, -1, 11'h7ff);
    queue_item(MODE_ADD, 32'sh5555_5555, 11'h555);
    queue_item(MODE_ADD, 32'shaaaa_aaaa, 11'h2aa);
    queue_item(MODE_LOOKUP, 32'sh1234_5678, 6);

    // random mix while the store grows
    repeat (574) queue_random(40);
    // top ranks, largest value and a late add
    queue_item(MODE_LOOKUP, 0, FIELD_W'(CAPACITY));
    queue_item(MODE_LOOKUP, 0, FIELD_W'(CAPACITY + 1));
    queue_item(MODE_RANK, VAL_MAX, 0);
    queue_item(MODE_ADD, $urandom, 0);

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    while (queued_requests.size() > 0 || start) @(posedge clk);
    while (pending_table_results.size() > 0) @(posedge clk);
    repeat (10) @(posedge clk);

    if (!mismatch_seen) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // run limit
  initial begin
    #2_000_000;
    $display("FAILURE");
    $finish;
  end

endmodule

// File: sim.f
hdl/sdrt_pkg.sv
hdl/sdrt_cell.sv
hdl/sdrt_reduce.sv
hdl/sorted_distinct_rank_table.sv
sim/tb_sorted_distinct_rank_table.sv
